/* design/stb_pkg.sv */
package stb_pkg;

	localparam int NUM_TIMERS_DEF = 16;
	localparam int MAX_SLOTS      = 16;  // ids are 4 bits wide
	localparam int ID_W           = 4;
	localparam int DATA_W         = 32;
	localparam int INTERVAL_W     = 16;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_ADD    = 2'd1,
		OP_REARM  = 2'd2,
		OP_DELETE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NOT_ACTIVE = 2'd1,
		ST_FULL       = 2'd2
	} status_t;

	typedef struct packed {
		op_t                       opcode;
		logic [ID_W-1:0]           timer_id;
		logic [DATA_W-1:0]         timeout;
		logic signed [DATA_W-1:0]  user_data;
	} tmr_req_t;

	typedef struct packed {
		status_t                   status;
		logic [ID_W-1:0]           result_id;
		logic signed [DATA_W-1:0]  expired_data;
		logic                      is_expiry;
		logic                      last;
	} tmr_rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FLUSH
	} stb_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load_op;     // execute add / rearm / delete, load response
		logic start_tick;  // begin slot scan
		logic scan_step;   // process current slot, advance index
		logic flush_push;  // send held expiry with last set
	} stb_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_space;   // output register can take a response this cycle
		logic hit;         // current slot is active and expires
		logic pend_valid;  // an expiry is held back
		logic scan_last;   // current slot is the final one
	} stb_sts_t;

endpackage

/* design/stb_ctrl.sv */
module stb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  stb_pkg::op_t        opcode,
	input  stb_pkg::stb_sts_t   sts,
	output logic                in_stall,
	output stb_pkg::stb_cmd_t   cmd
);
	import stb_pkg::*;

	stb_state_t state_q;
	stb_state_t state_d;
	logic       step_ok;

	// a second expiry may only be found once the held one can leave
	assign step_ok = !(sts.hit && sts.pend_valid && !sts.out_space);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid && sts.out_space && opcode == OP_TICK) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (step_ok && sts.scan_last) begin
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				if (!sts.pend_valid || sts.out_space) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall       = !sts.out_space;
				cmd.load_op    = in_valid && sts.out_space && opcode != OP_TICK;
				cmd.start_tick = in_valid && sts.out_space && opcode == OP_TICK;
			end
			S_SCAN: begin
				cmd.scan_step = step_ok;
			end
			S_FLUSH: begin
				cmd.flush_push = sts.pend_valid && sts.out_space;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

/* design/stb_dp.sv */
module stb_dp #(
	parameter int SLOT_COUNT = stb_pkg::MAX_SLOTS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [stb_pkg::INTERVAL_W-1:0]      cfg_wdata,
	input  stb_pkg::tmr_req_t                   req,
	input  logic                                out_stall,
	input  stb_pkg::stb_cmd_t                   cmd,
	output stb_pkg::stb_sts_t                   sts,
	output logic                                out_valid,
	output stb_pkg::tmr_rsp_t                   out_data
);
	import stb_pkg::*;

	localparam int IDX_W = $clog2(SLOT_COUNT);

	logic [SLOT_COUNT-1:0]       active_q;
	logic [DATA_W-1:0]           rem_q [SLOT_COUNT];
	logic signed [DATA_W-1:0]    data_q [SLOT_COUNT];
	logic [INTERVAL_W-1:0]       interval_q;
	logic [IDX_W-1:0]            idx_q;
	logic                        pend_valid_q;
	logic [IDX_W-1:0]            pend_id_q;
	logic signed [DATA_W-1:0]    pend_data_q;
	logic                        out_valid_q;
	tmr_rsp_t                    out_q;

	logic                        free_found;
	logic [IDX_W-1:0]            free_idx;
	logic [IDX_W-1:0]            req_idx;
	logic                        id_ok;
	logic [DATA_W-1:0]           interval_ext;
	logic [DATA_W-1:0]           cur_rem;
	logic                        hit;
	logic                        push_mid;
	logic                        take;
	tmr_rsp_t                    op_rsp;

	assign interval_ext = {{(DATA_W-INTERVAL_W){1'b0}}, interval_q};
	assign req_idx      = req.timer_id[IDX_W-1:0];
	assign id_ok        = ({{(32-ID_W){1'b0}}, req.timer_id} < 32'(SLOT_COUNT))
	                      && active_q[req_idx];
	assign cur_rem      = rem_q[idx_q];
	assign hit          = active_q[idx_q] && (cur_rem <= interval_ext);
	assign push_mid     = cmd.scan_step && hit && pend_valid_q;
	assign take         = out_valid_q && !out_stall;

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	always_comb begin
		op_rsp              = '0;
		op_rsp.last         = 1'b1;
		op_rsp.status       = ST_OK;
		case (req.opcode)
			OP_ADD: begin
				if (free_found) begin
					op_rsp.result_id = ID_W'(free_idx);
				end else begin
					op_rsp.status    = ST_FULL;
				end
			end
			OP_REARM, OP_DELETE: begin
				if (id_ok) begin
					op_rsp.result_id = req.timer_id;
				end else begin
					op_rsp.status    = ST_NOT_ACTIVE;
				end
			end
			default: begin
				op_rsp.status = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else begin
			if (cmd.load_op) begin
				if (req.opcode == OP_ADD && free_found) begin
					active_q[free_idx] <= 1'b1;
				end
				if (req.opcode == OP_DELETE && id_ok) begin
					active_q[req_idx] <= 1'b0;
				end
			end
			if (cmd.scan_step && hit) begin
				active_q[idx_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_op && req.opcode == OP_ADD && free_found) begin
			rem_q[free_idx]  <= req.timeout;
			data_q[free_idx] <= req.user_data;
		end
		if (cmd.load_op && req.opcode == OP_REARM && id_ok) begin
			rem_q[req_idx] <= req.timeout;
		end
		if (cmd.scan_step && active_q[idx_q] && !hit) begin
			rem_q[idx_q] <= cur_rem - interval_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q   <= INTERVAL_W'(1);
			idx_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				interval_q <= cfg_wdata;
			end
			if (cmd.start_tick) begin
				idx_q <= '0;
			end else if (cmd.scan_step) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.scan_step && hit) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.flush_push || cmd.start_tick) begin
				pend_valid_q <= 1'b0;
			end
			if (cmd.load_op || push_mid || cmd.flush_push) begin
				out_valid_q <= 1'b1;
			end else if (take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step && hit) begin
			pend_id_q   <= idx_q;
			pend_data_q <= data_q[idx_q];
		end
		if (cmd.load_op) begin
			out_q <= op_rsp;
		end else if (push_mid || cmd.flush_push) begin
			out_q.status       <= ST_OK;
			out_q.result_id    <= ID_W'(pend_id_q);
			out_q.expired_data <= pend_data_q;
			out_q.is_expiry    <= 1'b1;
			out_q.last         <= cmd.flush_push;
		end
	end

	assign sts.out_space  = !out_valid_q || !out_stall;
	assign sts.hit        = hit;
	assign sts.pend_valid = pend_valid_q;
	assign sts.scan_last  = idx_q == IDX_W'(SLOT_COUNT - 1);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* design/software_timer_bank.sv */
// Bank of countdown timer slots.
// Request channel (in_valid / in_stall / in_data): each request is a tick,
// an add, a rearm or a delete. Response channel (out_valid / out_stall /
// out_data): add, rearm and delete give exactly one response with last set.
// A tick gives one expiry response per expired slot, ascending slot order,
// last set on the final one; a tick that expires nothing gives no response.
// Add/rearm/delete respond in the cycle after acceptance and, unless the
// output stalls, the next request can be taken in that same cycle, so one
// per cycle sustained. A tick walks the SLOT_COUNT (min(NUM_TIMERS,16))
// slots one per cycle through the shared compare/subtract unit, then flushes,
// holding in_stall high throughout. One expiry is held back until the next
// is found so the last flag is known; a stalled output register stalls the
// scan when a further expiry is found and, in idle, holds in_stall high.
// cfg_we/cfg_wdata write tick_interval; write it only while idle.
// Reset (arst_n low, asynchronous) frees all slots, sets tick_interval to 1
// and empties the output register. Slot counts and data are not cleared.
module software_timer_bank #(
	parameter int NUM_TIMERS = stb_pkg::NUM_TIMERS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [stb_pkg::INTERVAL_W-1:0]  cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  stb_pkg::tmr_req_t               in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output stb_pkg::tmr_rsp_t               out_data
);
	import stb_pkg::*;

	// ids are 4 bits, so larger banks use only the first sixteen slots
	localparam int SLOT_COUNT = (NUM_TIMERS < MAX_SLOTS) ? NUM_TIMERS : MAX_SLOTS;

	stb_cmd_t cmd;
	stb_sts_t sts;

	stb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (in_data.opcode),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	stb_dp #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (in_data),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

	// held expiry is only released when the output register can take it
	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.flush_push || (cmd.scan_step && sts.hit && sts.pend_valid)) |-> sts.out_space)
		else $error("expiry pushed into a full output register");

	a_flush_has_pend: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush_push |-> sts.pend_valid)
		else $error("flush without a held expiry");

	// single-response requests show up in the next cycle
	a_op_responds: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && in_data.opcode != OP_TICK) |=> (out_valid && out_data.last))
		else $error("missing response for add/rearm/delete");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_op, cmd.start_tick, cmd.scan_step, cmd.flush_push}))
		else $error("conflicting datapath commands");

endmodule

/* dv/software_timer_bank_tb.sv */
`timescale 1ns / 1ps

module software_timer_bank_tb;
	import stb_pkg::*;

	// Generous bound: ~110 requests, each at worst the longest random gap, a full
	// scan and 16 expiry responses each waiting out the longest random stall,
	// plus the long receiver hold-off.
	localparam int CYCLE_LIMIT  = 500000;
	// A tick that expires nothing leaves no response behind, but the scan
	// still runs over every slot. Wait past that before a
	// register write or the end of the run.
	localparam int SCAN_SETTLE  = MAX_SLOTS + 8;
	localparam int HOLD_CYCLES  = 150;
	localparam int RAND_PER_SET = 15;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [INTERVAL_W-1:0]  cfg_wdata;
	logic                   in_valid;
	logic                   in_stall;
	tmr_req_t               in_data;
	logic                   out_valid;
	logic                   out_stall;
	tmr_rsp_t               out_data;

	// Slot model: mirrors the bank's table and the tick interval register.
	logic                   mdl_active [MAX_SLOTS];
	logic [DATA_W-1:0]      mdl_left   [MAX_SLOTS];
	logic [DATA_W-1:0]      mdl_data   [MAX_SLOTS];
	logic [INTERVAL_W-1:0]  mdl_ivl;

	tmr_rsp_t pending_rsp[$];   // responses owed by the bank, oldest first
	int       mismatches;

	// Knobs shared between the request driver and the response sink.
	bit tx_quiet;               // sender offers back to back
	bit rx_quiet;               // receiver never stalls
	int rx_hold_cycles;         // one-shot long stall, consumed by the sink

	software_timer_bank u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("status: fail");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	// Works out what one accepted request owes and updates the slot model.
	// Tick: every active slot whose count is not above the interval expires,
	// in ascending slot order, last flag on the final one; nothing expiring
	// means no response at all. Add takes the lowest free slot or reports
	// the table full. Rearm/delete of an inactive slot report not-active.
	function automatic void predict_timer_rsp(input tmr_req_t req);
		tmr_rsp_t rsp;
		tmr_rsp_t fired[$];
		int       slot;
		slot = -1;
		rsp = '0;
		rsp.status = ST_OK;
		rsp.last = 1'b1;
		case (req.opcode)
			OP_TICK: begin
				for (int i = 0; i < MAX_SLOTS; i++) begin
					if (mdl_active[i]) begin
						if (mdl_left[i] <= {16'd0, mdl_ivl}) begin
							mdl_active[i] = 1'b0;
							rsp = '0;
							rsp.status = ST_OK;
							rsp.result_id = ID_W'(i);
							rsp.expired_data = mdl_data[i];
							rsp.is_expiry = 1'b1;
							fired.push_back(rsp);
						end else begin
							mdl_left[i] = mdl_left[i] - {16'd0, mdl_ivl};
						end
					end
				end
				if (fired.size() > 0)
					fired[fired.size() - 1].last = 1'b1;
				foreach (fired[k])
					pending_rsp.push_back(fired[k]);
			end
			OP_ADD: begin
				for (int i = 0; i < MAX_SLOTS; i++)
					if (!mdl_active[i] && slot < 0)
						slot = i;
				if (slot < 0) begin
					rsp.status = ST_FULL;
				end else begin
					mdl_active[slot] = 1'b1;
					mdl_left[slot] = req.timeout;
					mdl_data[slot] = req.user_data;
					rsp.result_id = ID_W'(slot);
				end
				pending_rsp.push_back(rsp);
			end
			default: begin
				if (!mdl_active[req.timer_id]) begin
					rsp.status = ST_NOT_ACTIVE;
				end else begin
					if (req.opcode == OP_REARM)
						mdl_left[req.timer_id] = req.timeout;
					else
						mdl_active[req.timer_id] = 1'b0;
					rsp.result_id = req.timer_id;
				end
				pending_rsp.push_back(rsp);
			end
		endcase
	endfunction

	// Offer one request after a random gap; valid stays high on return so
	// a zero gap on the next call keeps the request stream back to back.
	task automatic send_req(input tmr_req_t req);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		do @(posedge clk); while (in_stall !== 1'b0);
		predict_timer_rsp(req);
	endtask

	task automatic send_op(input op_t op, input logic [ID_W-1:0] id,
			input logic [DATA_W-1:0] tmo, input logic [DATA_W-1:0] udata);
		tmr_req_t req;
		req.opcode = op;
		req.timer_id = id;
		req.timeout = tmo;
		req.user_data = udata;
		send_req(req);
	endtask

	// Drop valid, let every owed response arrive, then cover a silent scan.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (SCAN_SETTLE) @(posedge clk);
	endtask

	task automatic write_interval(input logic [INTERVAL_W-1:0] ivl);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= ivl;
		@(posedge clk);
		cfg_we  <= 1'b0;
		mdl_ivl = ivl;
	endtask

	// Response sink: random stall per response, plus a one-shot long hold.
	// Each accepted response is checked against the oldest expectation.
	initial begin : rsp_sink
		int       n;
		tmr_rsp_t want;
		forever begin
			if (rx_hold_cycles > 0) begin
				n = rx_hold_cycles;
				rx_hold_cycles = 0;
			end else begin
				n = rx_quiet ? 0 : $urandom_range(0, 16);
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			if (pending_rsp.size() == 0) begin
				report_mismatch($sformatf("unexpected response id %0d expiry %0b",
					out_data.result_id, out_data.is_expiry));
			end else begin
				want = pending_rsp.pop_front();
				if (out_data.status !== want.status)
					report_mismatch($sformatf("status want %0d got %0d",
						want.status, out_data.status));
				if (out_data.result_id !== want.result_id)
					report_mismatch($sformatf("result_id want %0d got %0d",
						want.result_id, out_data.result_id));
				if (out_data.expired_data !== want.expired_data)
					report_mismatch($sformatf("expired_data want %h got %h",
						want.expired_data, out_data.expired_data));
				if (out_data.is_expiry !== want.is_expiry)
					report_mismatch($sformatf("is_expiry want %0b got %0b",
						want.is_expiry, out_data.is_expiry));
				if (out_data.last !== want.last)
					report_mismatch($sformatf("last want %0b got %0b",
						want.last, out_data.last));
			end
		end
	end

	// Zero timeout expires on the next tick, max timeout survives it,
	// rearm/delete on live and dead slots, a tick that expires nothing.
	task automatic test_basic_ops();
		send_op(OP_ADD,    4'd9,  32'd0,          32'h7fff_ffff);  // slot 0
		send_op(OP_ADD,    4'd0,  32'd1,          32'h8000_0000);  // slot 1
		send_op(OP_ADD,    4'd15, 32'hffff_ffff,  32'hffff_ffff);  // slot 2
		send_op(OP_REARM,  4'd3,  32'd7,          32'd0);          // never added
		send_op(OP_DELETE, 4'd15, 32'd0,          32'd0);
		send_op(OP_TICK,   4'd0,  32'd0,          32'd0);          // 0 and 1 go
		send_op(OP_REARM,  4'd2,  32'd3,          32'd0);
		send_op(OP_DELETE, 4'd2,  32'd0,          32'd0);
		send_op(OP_DELETE, 4'd2,  32'd0,          32'd0);          // already gone
		send_op(OP_TICK,   4'd5,  32'hffff_ffff,  32'hffff_ffff);  // empty bank
	endtask

	// Fill all slots, overflow once, then drain with two ticks. The last slot
	// sits exactly on the 65535 interval after the first tick.
	task automatic test_table_full();
		for (int i = 0; i < MAX_SLOTS; i++)
			send_op(OP_ADD, ID_W'($urandom), (i == MAX_SLOTS - 1) ? 32'd65536 :
				32'($urandom_range(0, 3)), $urandom);
		send_op(OP_ADD, 4'd0, 32'd1, 32'd1);
		send_op(OP_TICK, 4'd0, 32'd0, 32'd0);
		write_interval(16'hffff);
		send_op(OP_TICK, 4'd0, 32'd0, 32'd0);
	endtask

	// Interval 0: only a slot holding zero expires, the rest do not move.
	task automatic test_zero_interval();
		write_interval(16'd0);
		send_op(OP_ADD,    4'd0, 32'd0, 32'h1234_5678);
		send_op(OP_ADD,    4'd0, 32'd5, 32'h0bad_cafe);
		send_op(OP_TICK,   4'd0, 32'd0, 32'd0);
		send_op(OP_DELETE, 4'd1, 32'd0, 32'd0);
	endtask

	// Receiver holds off for a long stretch while the sender keeps offering,
	// so the output register fills and the bank stalls its request side.
	task automatic test_backpressure();
		write_interval(16'd1);
		tx_quiet = 1'b1;
		rx_hold_cycles = HOLD_CYCLES;
		for (int i = 0; i < 12; i++)
			send_op((i % 4 == 3) ? OP_REARM : OP_ADD, ID_W'($urandom_range(0, 3)),
				32'($urandom_range(0, 6)), $urandom);
		send_op(OP_TICK, 4'd0, 32'd0, 32'd0);
		tx_quiet = 1'b0;
	endtask

	// Random mix per interval setting. Rearm/delete mostly aim at live slots
	// so they get past the not-active check; timeouts are mostly on the
	// scale of the interval so ticks really expire things.
	task automatic test_random_mix();
		tmr_req_t req;
		int       live[$];
		int       pick;
		int       tsel;
		logic [INTERVAL_W-1:0] ivl;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: ivl = 16'd1;
				1: ivl = INTERVAL_W'($urandom_range(2, 9));
				2: ivl = 16'hffff;
				default: ivl = 16'd1;
			endcase
			write_interval(ivl);
			// last setting runs with no idling on either side
			tx_quiet = (ph == 3);
			rx_quiet = (ph == 3);
			for (int n = 0; n < RAND_PER_SET; n++) begin
				req.timer_id = ID_W'($urandom);
				req.user_data = $urandom;
				tsel = $urandom_range(0, 9);
				case (tsel)
					0: req.timeout = $urandom;
					1: req.timeout = '0;
					2: req.timeout = '1;
					default: req.timeout = 32'($urandom_range(0, 4 * int'(ivl) + 4));
				endcase
				pick = $urandom_range(0, 99);
				if (pick < 35)
					req.opcode = OP_ADD;
				else if (pick < 65)
					req.opcode = OP_TICK;
				else if (pick < 82)
					req.opcode = OP_REARM;
				else
					req.opcode = OP_DELETE;
				if (req.opcode == OP_REARM || req.opcode == OP_DELETE) begin
					live.delete();
					for (int i = 0; i < MAX_SLOTS; i++)
						if (mdl_active[i])
							live.push_back(i);
					if (live.size() > 0 && $urandom_range(0, 4) != 0)
						req.timer_id = ID_W'(live[$urandom_range(0, live.size() - 1)]);
				end
				send_req(req);
			end
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	initial begin : stimulus
		mismatches = 0;
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		rx_hold_cycles = 0;
		mdl_ivl = 16'd1;
		foreach (mdl_active[i])
			mdl_active[i] = 1'b0;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_ops();
		test_table_full();
		test_zero_interval();
		test_backpressure();
		test_random_mix();

		wait_drained();
		if (mismatches == 0 && pending_rsp.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

/* sim.f */
design/stb_pkg.sv
design/stb_ctrl.sv
design/stb_dp.sv
design/software_timer_bank.sv
dv/software_timer_bank_tb.sv
